@@ rtl/pidl_pkg.sv @@
// Package for the PID controller with output lag: payload structs, sequencer
// states, register indexes and fixed widths. No dependencies.
`timescale 1ns / 1ps

package pidl_pkg;

  // Fixed widths of the datapath.
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = SAMPLE_W + 1;
  localparam int DIFF_W    = SAMPLE_W + 2;
  localparam int OPA_W     = SUM_W + 1;
  localparam int OPB_W     = GAIN_W + 1;
  localparam int PROD_W    = OPA_W + OPB_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int CTRL_FRAC = 12;
  localparam int LAG_FRAC  = 16;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_ALPHA   = 3'd4;

  // Reset values of the gains.
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd4915;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd164;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd2048;
  localparam logic [GAIN_W-1:0] LAG_ALPHA_RST  = 16'd3277;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] measured_temp;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] control_value;
    logic signed [SAMPLE_W-1:0] lagged_output;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    value;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_CTRL,
    S_MUL_L,
    S_LAG
  } state_e;

endpackage

@@ rtl/pidl_stream_if.sv @@
// Valid/ready channel carrying one payload struct per transaction.
// The payload type comes from pidl_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface pidl_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pid_with_output_lag_top.sv @@
// Discrete PID controller with a first-order lag on its output.
// Depends on pidl_pkg and pidl_stream_if.
`timescale 1ns / 1ps

// Each sample transaction on sample_i carries one signed Q8.8 temperature.
// The block forms the error against the setpoint, updates a saturating
// 32-bit error sum and the error difference, and computes the control value
// kp*e + ki*sum + kd*diff with Q4.12 gains, rounded half up to Q8.8 and
// saturated to 16 bits. A lag output then moves toward the control value by
// the Q0.16 fraction lag_alpha and saturates too. One result transaction on
// result_o carries both values. All four products go through one shared
// 33x17 multiplier whose product is registered; a sample passes through
// the steps error, three gain products, accumulate, control, lag product and
// lag; sample_i.ready is high only while the sequencer is idle. The result
// sits in an output register, so a new sample can be accepted while the
// previous result waits to be taken; only a second finished result waits
// in the last step for that register to free up. Configuration writes on
// cfg_i are always accepted and must arrive only while the block is idle;
// writes to indexes beyond the lag fraction are ignored.
module pid_with_output_lag_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  pidl_stream_if.sink    sample_i,
  pidl_stream_if.source  result_o,
  pidl_stream_if.sink    cfg_i
);
  import pidl_pkg::*;

  localparam int SAT_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_MIN = -(2 ** (SAMPLE_W - 1));

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] target_q;
  logic        [GAIN_W-1:0]   prop_gain_q;
  logic        [GAIN_W-1:0]   integ_gain_q;
  logic        [GAIN_W-1:0]   deriv_gain_q;
  logic        [GAIN_W-1:0]   lag_alpha_q;

  // Controller state.
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [ERR_W-1:0]    last_err_q;
  logic signed [SAMPLE_W-1:0] lag_q;

  // Working registers of one sample.
  state_e                     state_q, state_d;
  logic signed [SAMPLE_W-1:0] meas_q;
  logic signed [ERR_W-1:0]    err_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [SAMPLE_W-1:0] ctrl_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  // Output register.
  logic    out_valid_q;
  result_t out_data_q;

  // Combinational datapath.
  logic signed [ERR_W-1:0]    err_c;
  logic signed [DIFF_W-1:0]   diff_c;
  logic signed [SUM_W:0]      sum_wide_c;
  logic signed [SUM_W-1:0]    sum_sat_c;
  logic signed [ERR_W-1:0]    lag_gap_c;
  logic signed [OPA_W-1:0]    op_a_c;
  logic        [GAIN_W-1:0]   gain_c;
  logic signed [OPB_W-1:0]    op_b_c;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [ACC_W-1:0]    acc_rnd_c;
  logic signed [ACC_W-1:0]    acc_shift_c;
  logic signed [SAMPLE_W-1:0] ctrl_sat_c;
  logic signed [PROD_W-1:0]   lag_rnd_c;
  logic signed [PROD_W-1:0]   lag_sum_c;
  logic signed [SAMPLE_W-1:0] lag_sat_c;

  logic sample_accept;
  logic load_out;

  assign sample_accept = sample_i.valid && sample_i.ready;
  assign cfg_i.ready   = 1'b1;

  // Error, difference and saturating error sum, all from the captured sample.
  always_comb begin
    err_c      = ERR_W'(target_q) - ERR_W'(meas_q);
    diff_c     = DIFF_W'(err_c) - DIFF_W'(last_err_q);
    sum_wide_c = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(err_c);
    if (sum_wide_c[SUM_W] != sum_wide_c[SUM_W-1]) begin
      sum_sat_c = sum_wide_c[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                    : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat_c = sum_wide_c[SUM_W-1:0];
    end
  end

  // The shared multiplier: operand selection follows the sequencer step.
  always_comb begin
    lag_gap_c = ERR_W'(ctrl_q) - ERR_W'(lag_q);
    case (state_q)
      S_MUL_P: begin
        op_a_c = OPA_W'(err_q);
        gain_c = prop_gain_q;
      end
      S_MUL_I: begin
        op_a_c = OPA_W'(sum_q);
        gain_c = integ_gain_q;
      end
      S_MUL_D: begin
        op_a_c = OPA_W'(diff_q);
        gain_c = deriv_gain_q;
      end
      default: begin
        op_a_c = OPA_W'(lag_gap_c);
        gain_c = lag_alpha_q;
      end
    endcase
    op_b_c = $signed({1'b0, gain_c});
    prod_c = op_a_c * op_b_c;
  end

  // Round half up to Q8.8 and saturate, for the control value and the lag.
  always_comb begin
    acc_rnd_c   = acc_q + ACC_W'(2 ** (CTRL_FRAC - 1));
    acc_shift_c = acc_rnd_c >>> CTRL_FRAC;
    if (acc_shift_c > ACC_W'(SAT_MAX)) begin
      ctrl_sat_c = SAMPLE_W'(SAT_MAX);
    end else if (acc_shift_c < ACC_W'(SAT_MIN)) begin
      ctrl_sat_c = SAMPLE_W'(SAT_MIN);
    end else begin
      ctrl_sat_c = acc_shift_c[SAMPLE_W-1:0];
    end

    lag_rnd_c = prod_q + PROD_W'(2 ** (LAG_FRAC - 1));
    lag_sum_c = PROD_W'(lag_q) + (lag_rnd_c >>> LAG_FRAC);
    if (lag_sum_c > PROD_W'(SAT_MAX)) begin
      lag_sat_c = SAMPLE_W'(SAT_MAX);
    end else if (lag_sum_c < PROD_W'(SAT_MIN)) begin
      lag_sat_c = SAMPLE_W'(SAT_MIN);
    end else begin
      lag_sat_c = lag_sum_c[SAMPLE_W-1:0];
    end
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_d         = state_q;
    sample_i.ready  = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      S_IDLE: begin
        sample_i.ready = 1'b1;
        if (sample_i.valid) state_d = S_ERR;
      end
      S_ERR:   state_d = S_MUL_P;
      S_MUL_P: state_d = S_MUL_I;
      S_MUL_I: state_d = S_MUL_D;
      S_MUL_D: state_d = S_ACC;
      S_ACC:   state_d = S_CTRL;
      S_CTRL:  state_d = S_MUL_L;
      S_MUL_L: state_d = S_LAG;
      S_LAG: begin
        // Hold here until the output register can take the result.
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= '0;
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      lag_alpha_q  <= LAG_ALPHA_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_TARGET_TEMP: target_q     <= $signed(cfg_i.data.value[SAMPLE_W-1:0]);
        CFG_PROP_GAIN:   prop_gain_q  <= cfg_i.data.value;
        CFG_INTEG_GAIN:  integ_gain_q <= cfg_i.data.value;
        CFG_DERIV_GAIN:  deriv_gain_q <= cfg_i.data.value;
        CFG_LAG_ALPHA:   lag_alpha_q  <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // Controller state: error sum and last error update in the error step,
  // the lag state when the result is handed to the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      last_err_q <= '0;
      lag_q      <= '0;
    end else begin
      if (state_q == S_ERR) begin
        sum_q      <= sum_sat_c;
        last_err_q <= err_c;
      end
      if (load_out) lag_q <= lag_sat_c;
    end
  end

  // Working registers; the product of each gain step is accumulated in the next.
  always_ff @(posedge clk_i) begin
    if (sample_accept) meas_q <= sample_i.data.measured_temp;
    case (state_q)
      S_ERR: begin
        err_q  <= err_c;
        diff_q <= diff_c;
      end
      S_MUL_P: prod_q <= prod_c;
      S_MUL_I: begin
        prod_q <= prod_c;
        acc_q  <= ACC_W'(prod_q);
      end
      S_MUL_D: begin
        prod_q <= prod_c;
        acc_q  <= acc_q + ACC_W'(prod_q);
      end
      S_ACC:   acc_q  <= acc_q + ACC_W'(prod_q);
      S_CTRL:  ctrl_q <= ctrl_sat_c;
      S_MUL_L: prod_q <= prod_c;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.control_value <= ctrl_q;
      out_data_q.lagged_output <= lag_sat_c;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for pid_with_output_lag_top: drives temperature samples and
// register writes, predicts every control and lag value, and checks each result.
// Depends on pidl_pkg, pidl_stream_if and the top level of the block.
`timescale 1ns / 1ps

module tb;
  import pidl_pkg::*;

  // Percentage of cycles in which either side idles at random.
  localparam int IDLE_PCT       = 17;
  // Length of the long receiver hold-off and the results after which it starts.
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_FIRST  = 400;
  localparam int HOLD_AT_SECOND = 900;
  // Quiet cycles after the last result, in which the block is already idle,
  // before any register is written.
  localparam int SETTLE_CYCLES  = 12;
  // The longest correct quiet spell is the receiver hold-off plus one sample of
  // work and a few idle cycles; the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MISMATCH_SHOWN = 10;
  localparam int RANDOM_PHASES  = 5;
  localparam int MAX_ERR        = (1 << SAMPLE_W) - 1;

  typedef logic signed [SAMPLE_W-1:0] temp_t;

  logic clk;
  logic rst_n;

  pidl_stream_if #(.data_t(sample_t)) sample_if ();
  pidl_stream_if #(.data_t(result_t)) result_if ();
  pidl_stream_if #(.data_t(cfg_t))    cfg_if ();

  pid_with_output_lag_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // Shadow copy of the registers, starting from their reset values.
  temp_t             setpoint = '0;
  logic [GAIN_W-1:0] kp       = PROP_GAIN_RST;
  logic [GAIN_W-1:0] ki       = INTEG_GAIN_RST;
  logic [GAIN_W-1:0] kd       = DERIV_GAIN_RST;
  logic [GAIN_W-1:0] alpha    = LAG_ALPHA_RST;

  // Shadow copy of the controller state.
  logic signed [SUM_W-1:0] err_sum  = '0;
  logic signed [ERR_W-1:0] last_err = '0;
  temp_t                   lag_q    = '0;

  sample_t temp_q[$];            // samples waiting to be offered
  result_t expected_outputs[$];  // predicted results, oldest first

  int items_pushed    = 0;
  int samples_taken   = 0;
  int results_seen    = 0;
  int mismatches      = 0;
  int cfg_writes      = 0;
  int settings_seen   = 0;
  int quiet_cycles    = 0;
  int hold_left       = 0;
  int results_at_sink = 0;
  logic no_idle       = 1'b0;

  // The clock runs from time zero with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // One controller step: the error sum is updated before the control value uses
  // it, and the previous error is replaced after the derivative term is formed.
  function automatic result_t pid_lag_step(input temp_t meas);
    longint  err;
    longint  diff;
    longint  sum_next;
    longint  acc;
    longint  ctrl;
    longint  delta;
    longint  lag_next;
    result_t r;
    err      = longint'(setpoint) - longint'(meas);
    diff     = err - longint'(last_err);
    sum_next = clamp_to(longint'(err_sum) + err, SUM_W);
    err_sum  = sum_next[SUM_W-1:0];
    acc      = longint'(kp) * err + longint'(ki) * sum_next + longint'(kd) * diff;
    ctrl     = clamp_to((acc + (longint'(1) <<< (CTRL_FRAC - 1))) >>> CTRL_FRAC, SAMPLE_W);
    last_err = err[ERR_W-1:0];
    delta    = ((ctrl - longint'(lag_q)) * longint'(alpha)
               + (longint'(1) <<< (LAG_FRAC - 1))) >>> LAG_FRAC;
    lag_next = clamp_to(longint'(lag_q) + delta, SAMPLE_W);
    lag_q    = lag_next[SAMPLE_W-1:0];
    r.control_value = ctrl[SAMPLE_W-1:0];
    r.lagged_output = lag_q;
    return r;
  endfunction

  // Writes to indexes past the lag fraction leave every register unchanged.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [GAIN_W-1:0] val);
    case (idx)
      CFG_TARGET_TEMP: setpoint = val;
      CFG_PROP_GAIN:   kp       = val;
      CFG_INTEG_GAIN:  ki       = val;
      CFG_DERIV_GAIN:  kd       = val;
      CFG_LAG_ALPHA:   alpha    = val;
      default: ;
    endcase
  endfunction

  // Sample driver. A new sample is offered only once the previous one has been
  // taken, so valid gets a single assignment per edge.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      sample_if.valid <= 1'b0;
      sample_if.data  <= '0;
    end else if (!sample_if.valid || sample_if.ready) begin
      if (temp_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        sample_if.data  <= temp_q.pop_front();
        sample_if.valid <= 1'b1;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Every sample the block takes goes through the predictor at that edge.
  always @(posedge clk) begin
    if (rst_n && sample_if.valid && sample_if.ready) begin
      expected_outputs.push_back(pid_lag_step(sample_if.data.measured_temp));
      samples_taken++;
    end
  end

  // Result receiver. Besides idling at random it holds off twice for a long
  // stretch, so the block fills its output register, finishes one more sample
  // and then stalls the sample channel while the sender keeps offering.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_at_sink++;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (result_if.valid && result_if.ready &&
                   (results_at_sink == HOLD_AT_FIRST ||
                    results_at_sink == HOLD_AT_SECOND)) begin
        hold_left = HOLD_CYCLES;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Result checker: every result transaction is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && result_if.valid && result_if.ready) begin
      got = result_if.data;
      results_seen++;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN) begin
          $display("%0t: result with nothing expected: control %0d lag %0d",
                   $realtime, got.control_value, got.lagged_output);
        end
      end else begin
        want = expected_outputs.pop_front();
        if (got.control_value !== want.control_value ||
            got.lagged_output !== want.lagged_output) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN) begin
            $display("%0t: result %0d: control exp %0d got %0d, lag exp %0d got %0d",
                     $realtime, results_seen, want.control_value, got.control_value,
                     want.lagged_output, got.lagged_output);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction completes on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic void push_temp(input int t);
    temp_q.push_back(sample_t'(SAMPLE_W'(t)));
    items_pushed++;
  endfunction

  // A slowly drifting temperature around a center, with a share of samples
  // anywhere in the full range as noise.
  task automatic push_walk(input int n, input int center, input int noise_pct);
    int cur;
    cur = center;
    @(negedge clk);
    repeat (n) begin
      if ($urandom_range(99) < noise_pct) begin
        push_temp(int'(temp_t'($urandom_range(MAX_ERR))));
      end else begin
        cur += int'($urandom_range(512)) - 256;
        if (cur > 32767) cur = 32767;
        if (cur < -32768) cur = -32768;
        push_temp(cur);
      end
    end
  endtask

  // Waits until every sample pushed so far has produced its result, then lets
  // the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (results_seen < items_pushed);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge; leaves valid high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.value <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    apply_reg(idx, val);
    cfg_writes++;
  endtask

  // Writes all five registers and one unused index, whose write must be ignored.
  task automatic cfg_all(input int sp, input int p, input int i, input int d, input int a);
    @(posedge clk);
    write_reg(CFG_TARGET_TEMP, GAIN_W'(sp));
    write_reg(CFG_PROP_GAIN, GAIN_W'(p));
    write_reg(CFG_INTEG_GAIN, GAIN_W'(i));
    write_reg(CFG_DERIV_GAIN, GAIN_W'(d));
    write_reg(CFG_LAG_ALPHA, GAIN_W'(a));
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_LAG_ALPHA + 1)),
              GAIN_W'($urandom_range(MAX_ERR)));
    cfg_if.valid <= 1'b0;
    settings_seen++;
  endtask

  initial begin
    int i;
    // All inputs of the block are known from time zero.
    rst_n             = 1'b0;
    sample_if.valid   = 1'b0;
    sample_if.data    = '0;
    result_if.ready   = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples under the reset settings. The first one has a nonzero
    // error, so the derivative term sees all of it; the extremes push the
    // control value into both clamps and set every sample bit both ways.
    @(negedge clk);
    push_temp(1000);
    push_temp(32767);
    push_temp(-32768);
    push_temp(-32768);
    push_temp(32767);
    push_temp(-1);
    push_temp(1);
    push_temp(0);
    push_temp(int'(temp_t'(16'h5555)));
    push_temp(int'(temp_t'(16'hAAAA)));
    push_temp(256);
    push_temp(-256);
    for (i = 0; i < 4; i++) push_temp(6400);
    push_temp(-6400);
    push_temp(12345);
    push_temp(-12345);
    wait_idle();

    // Nominal gains around a room-temperature setpoint.
    cfg_all(6400, PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, LAG_ALPHA_RST);
    push_walk(300, 6000, 10);
    wait_idle();

    // Everything at its maximum, lowest setpoint.
    cfg_all(-32768, MAX_ERR, MAX_ERR, MAX_ERR, MAX_ERR);
    push_walk(120, -20000, 20);
    wait_idle();

    // All gains and the lag fraction at zero, highest setpoint, and no idling
    // on either side for this stretch.
    cfg_all(32767, 0, 0, 0, 0);
    @(posedge clk);
    no_idle <= 1'b1;
    push_walk(100, 0, 50);
    wait_idle();
    no_idle <= 1'b0;

    // Random settings; about half of them keep the gains small so the controller
    // works away from its clamps.
    for (i = 0; i < RANDOM_PHASES; i++) begin
      if ($urandom_range(1) == 1) begin
        cfg_all($urandom_range(MAX_ERR), $urandom_range(8192), $urandom_range(512),
                $urandom_range(8192), $urandom_range(MAX_ERR));
      end else begin
        cfg_all($urandom_range(MAX_ERR), $urandom_range(MAX_ERR), $urandom_range(MAX_ERR),
                $urandom_range(MAX_ERR), $urandom_range(MAX_ERR));
      end
      push_walk(140, int'(setpoint) + int'($urandom_range(2048)) - 1024, 15);
      wait_idle();
    end

    $display("Checked %0d results for %0d samples under %0d register settings",
             results_seen, samples_taken, settings_seen + 1);
    $display("(%0d register writes), with random idling and two long receiver hold-offs.",
             cfg_writes);
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
